// ----- rtl/cpif_pkg.sv -----
`timescale 1ns / 1ps

package cpif_pkg;

   // parameter defaults
   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 4096;
   localparam int CHANNELS_DEF   = 3;

   // field and counter widths
   localparam int SAMPLE_W   = 8;
   localparam int MODE_W     = 3;
   localparam int WID_W      = 12;
   localparam int HGT_W      = 13;
   localparam int TOTAL_W    = WID_W + HGT_W;
   localparam int ITEMS_W    = 24;
   localparam int EMIT_W     = 23;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_VALUE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR_MODE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd4;

   // kernel codes
   localparam logic [MODE_W-1:0] MODE_SMOOTH  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_BLUR    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SHARPEN = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MEAN    = 3'd3;
   localparam logic [MODE_W-1:0] MODE_EMBOSS  = 3'd4;

   // reset values
   localparam logic [MODE_W-1:0]   RST_FILTER_MODE  = MODE_SMOOTH;
   localparam logic [SAMPLE_W-1:0] RST_MAX_VALUE    = 8'd255;
   localparam logic                RST_COLOR_MODE   = 1'b1;
   localparam logic [WID_W-1:0]    RST_IMAGE_WIDTH  = 12'd640;
   localparam logic [HGT_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;

   // reciprocals for floor division of values below 4096
   localparam int          RECIP_SHIFT = 16;
   localparam logic [15:0] RECIP_NINE  = 16'd7282;
   localparam logic [15:0] RECIP_THREE = 16'd21846;

   // result queue
   localparam int OUTQ_DEPTH = 8;
   localparam int OUTQ_AW    = 3;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_RUN,
      ST_DIV
   } state_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_a;
      logic [SAMPLE_W-1:0] sample_b;
      logic [SAMPLE_W-1:0] sample_c;
      logic                flush;
   } req_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] result_a;
      logic [SAMPLE_W-1:0] result_b;
      logic [SAMPLE_W-1:0] result_c;
      logic                frame_last;
   } rsp_type;

   // per-item position info carried down the pipe
   typedef struct packed {
      logic emit;
      logic last;
      logic top;
      logic bot;
      logic left;
      logic right;
   } pos_type;

endpackage

// ----- rtl/conv3x3_preset_image_filter.sv -----
`timescale 1ns / 1ps

// 3x3 preset image filter. Pixels enter in raster order on req_, one transfer per clock while
// req_ready is high, and results leave on rsp_ in the same order; each input item after the first
// image_width+1 of a frame yields the pixel image_width+1 positions earlier, so the host closes
// every frame with image_width+1 flush items. Kernels: smooth, blur, sharpen, mean, emboss;
// samples outside the frame count as zero, results are floor(sum/d) clamped to 0..max_value
// (d is 9 smooth, 16 blur, 3 sharpen, 1 mean and emboss). Sustained rate is one item per clock
// while the result queue has room, set by the single line memory that is read and written back
// once per column. After reset a clearing pass zeroes the line memory, and each register write
// starts a recompute of the column and row counters for the new geometry; req_ready and csr_ready
// are low during both. Write registers only while no results are outstanding.
module conv3x3_preset_image_filter #(
   parameter int MAX_WIDTH  = cpif_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = cpif_pkg::MAX_HEIGHT_DEF,
   parameter int CHANNELS   = cpif_pkg::CHANNELS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  cpif_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output cpif_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cpif_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpif_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int PIX_W  = cpif_pkg::SAMPLE_W * CHANNELS;
   localparam int LINE_W = 2 * PIX_W;
   localparam int WW     = cpif_pkg::WID_W;
   localparam int IW     = cpif_pkg::ITEMS_W;
   localparam int EW     = cpif_pkg::EMIT_W;
   localparam int QA     = cpif_pkg::OUTQ_AW;

   // ---------------------------------------------------------------- configuration
   logic [cpif_pkg::MODE_W-1:0]   mode_ff;
   logic [cpif_pkg::SAMPLE_W-1:0] maxv_ff;
   logic                          color_ff;
   logic [WW-1:0]                 width_ff;
   logic [cpif_pkg::HGT_W-1:0]    height_ff;
   logic [WW-1:0]                 w_eff;
   logic [cpif_pkg::HGT_W-1:0]    h_eff;
   logic [cpif_pkg::TOTAL_W-1:0]  total_ff;
   logic                          csr_fire;

   assign csr_fire = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= cpif_pkg::RST_FILTER_MODE;
         maxv_ff   <= cpif_pkg::RST_MAX_VALUE;
         color_ff  <= cpif_pkg::RST_COLOR_MODE;
         width_ff  <= cpif_pkg::RST_IMAGE_WIDTH;
         height_ff <= cpif_pkg::RST_IMAGE_HEIGHT;
      end else if (csr_fire) begin
         case (csr_index)
            cpif_pkg::REG_FILTER_MODE:  mode_ff   <= csr_wdata[cpif_pkg::MODE_W-1:0];
            cpif_pkg::REG_MAX_VALUE:    maxv_ff   <= csr_wdata[cpif_pkg::SAMPLE_W-1:0];
            cpif_pkg::REG_COLOR_MODE:   color_ff  <= csr_wdata[0];
            cpif_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata[WW-1:0];
            cpif_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // geometry clamped to the supported range
   always_comb begin
      if (width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = width_ff;
      end
      if (height_ff == '0) begin
         h_eff = cpif_pkg::HGT_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = cpif_pkg::HGT_W'(MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
   end

   // frame size; settles during the recompute after any write
   always_ff @(posedge clock) begin
      total_ff <= cpif_pkg::TOTAL_W'(w_eff) * cpif_pkg::TOTAL_W'(h_eff);
   end

   // ---------------------------------------------------------------- control
   cpif_pkg::state_type state_ff, state_in;
   logic [AW-1:0]       clr_ff;
   logic [4:0]          div_cnt_ff, div_cnt_in;
   logic [QA:0]         outq_cnt_ff;
   logic [4:0]          inflight;
   logic                room;
   logic                acc;
   logic                s1_vld_ff, s2_vld_ff, s3_vld_ff;
   cpif_pkg::pos_type   s1_pos_ff, s2_pos_ff, s3_pos_ff;

   assign inflight = 5'(s1_vld_ff && s1_pos_ff.emit) + 5'(s2_vld_ff) + 5'(s3_vld_ff);
   assign room     = (5'(outq_cnt_ff) + inflight) < 5'(cpif_pkg::OUTQ_DEPTH);
   assign acc      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpif_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // a pending register write holds off input so the counters see one event per cycle
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      csr_ready = 1'b0;
      case (state_ff)
         cpif_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(MAX_WIDTH - 1)) state_in = cpif_pkg::ST_RUN;
         end
         cpif_pkg::ST_RUN: begin
            req_ready = room && !csr_valid;
            csr_ready = 1'b1;
            if (csr_valid) state_in = cpif_pkg::ST_DIV;
         end
         cpif_pkg::ST_DIV: begin
            if (div_cnt_ff == 5'd1) state_in = cpif_pkg::ST_RUN;
         end
         default: state_in = cpif_pkg::ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (state_ff == cpif_pkg::ST_CLEAR) begin
         clr_ff <= clr_ff + AW'(1);
      end
   end

   // ---------------------------------------------------------------- position counters
   logic [IW-1:0] items_ff, items_in;
   logic [EW-1:0] emitted_ff, emitted_in;
   logic [WW-1:0] col_ff, col_in;
   logic [WW-1:0] cpos_ff, cpos_in;
   logic [EW-1:0] rpos_ff, rpos_in;
   // restoring dividers for the recompute: items mod width, emitted divmod width
   logic [IW-1:0] dvd_n_ff, dvd_n_in, dvd_p_ff, dvd_p_in;
   logic [WW-1:0] rem_n_ff, rem_n_in, rem_p_ff, rem_p_in;
   logic [WW:0]   rem_n_t, rem_p_t;
   logic          qbit;
   logic          emit0, last0;
   cpif_pkg::pos_type pos0;

   assign emit0 = (25'(items_ff) >= (25'(w_eff) + 25'd1));
   assign last0 = emit0 && ((cpif_pkg::TOTAL_W'(emitted_ff) + cpif_pkg::TOTAL_W'(1)) >= total_ff);

   always_comb begin
      pos0.emit  = emit0;
      pos0.last  = last0;
      pos0.top   = (rpos_ff == '0);
      pos0.bot   = ((24'(rpos_ff) + 24'd1) >= 24'(h_eff));
      pos0.left  = (cpos_ff == '0);
      pos0.right = ((13'(cpos_ff) + 13'd1) >= 13'(w_eff));
   end

   always_comb begin
      items_in   = items_ff;
      emitted_in = emitted_ff;
      col_in     = col_ff;
      cpos_in    = cpos_ff;
      rpos_in    = rpos_ff;
      dvd_n_in   = dvd_n_ff;
      dvd_p_in   = dvd_p_ff;
      rem_n_in   = rem_n_ff;
      rem_p_in   = rem_p_ff;
      div_cnt_in = div_cnt_ff;
      rem_n_t    = {rem_n_ff, dvd_n_ff[IW-1]};
      rem_p_t    = {rem_p_ff, dvd_p_ff[IW-1]};
      qbit       = (rem_p_t >= (WW+1)'(w_eff));
      if (rem_n_t >= (WW+1)'(w_eff)) rem_n_t = rem_n_t - (WW+1)'(w_eff);
      if (qbit) rem_p_t = rem_p_t - (WW+1)'(w_eff);
      if (state_ff == cpif_pkg::ST_DIV) begin
         rem_n_in   = rem_n_t[WW-1:0];
         rem_p_in   = rem_p_t[WW-1:0];
         dvd_n_in   = {dvd_n_ff[IW-2:0], 1'b0};
         dvd_p_in   = {dvd_p_ff[IW-2:0], qbit};
         div_cnt_in = div_cnt_ff - 5'd1;
         if (div_cnt_ff == 5'd1) begin
            col_in  = rem_n_t[WW-1:0];
            cpos_in = rem_p_t[WW-1:0];
            rpos_in = dvd_p_in[EW-1:0];
         end
      end else if (csr_fire) begin
         dvd_n_in   = items_ff;
         dvd_p_in   = IW'(emitted_ff);
         rem_n_in   = '0;
         rem_p_in   = '0;
         div_cnt_in = 5'(IW);
      end else if (acc) begin
         if (last0) begin
            items_in   = '0;
            col_in     = '0;
            emitted_in = '0;
            cpos_in    = '0;
            rpos_in    = '0;
         end else begin
            if (!(&items_ff)) begin
               items_in = items_ff + IW'(1);
               col_in   = ((13'(col_ff) + 13'd1) == 13'(w_eff)) ? '0 : col_ff + WW'(1);
            end
            if (emit0) begin
               emitted_in = emitted_ff + EW'(1);
               if ((13'(cpos_ff) + 13'd1) == 13'(w_eff)) begin
                  cpos_in = '0;
                  rpos_in = rpos_ff + EW'(1);
               end else begin
                  cpos_in = cpos_ff + WW'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         items_ff   <= '0;
         emitted_ff <= '0;
         col_ff     <= '0;
         cpos_ff    <= '0;
         rpos_ff    <= '0;
         div_cnt_ff <= '0;
      end else begin
         items_ff   <= items_in;
         emitted_ff <= emitted_in;
         col_ff     <= col_in;
         cpos_ff    <= cpos_in;
         rpos_ff    <= rpos_in;
         div_cnt_ff <= div_cnt_in;
      end
      dvd_n_ff <= dvd_n_in;
      dvd_p_ff <= dvd_p_in;
      rem_n_ff <= rem_n_in;
      rem_p_ff <= rem_p_in;
   end

   // ---------------------------------------------------------------- line memory
   // one word per column: {row two above, row above}
   logic [LINE_W-1:0] line_mem [MAX_WIDTH];
   logic [LINE_W-1:0] rd_ff, fwd_data_ff, line_q, mem_wd;
   logic [AW-1:0]     rd_addr, mem_wa, s1_col_ff;
   logic              mem_we, fwd_ff;
   logic [PIX_W-1:0]  pix0, s1_pix_ff, s1_up, s1_mid;

   assign pix0    = req_data.flush ? '0
                  : PIX_W'({req_data.sample_c, req_data.sample_b, req_data.sample_a});
   assign rd_addr = AW'(col_ff);
   assign line_q  = fwd_ff ? fwd_data_ff : rd_ff;
   assign s1_up   = line_q[LINE_W-1:PIX_W];
   assign s1_mid  = line_q[PIX_W-1:0];
   assign mem_we  = (state_ff == cpif_pkg::ST_CLEAR) || s1_vld_ff;
   assign mem_wa  = (state_ff == cpif_pkg::ST_CLEAR) ? clr_ff : s1_col_ff;
   assign mem_wd  = (state_ff == cpif_pkg::ST_CLEAR) ? '0 : {s1_mid, s1_pix_ff};

   always_ff @(posedge clock) begin
      if (acc) rd_ff <= line_mem[rd_addr];
      if (mem_we) line_mem[mem_wa] <= mem_wd;
   end

   // back-to-back transfers on the same column (width one): bypass the pending write
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else begin
         fwd_ff <= acc && s1_vld_ff && (s1_col_ff == rd_addr);
      end
      fwd_data_ff <= {s1_mid, s1_pix_ff};
   end

   // ---------------------------------------------------------------- pipe stages
   logic [PIX_W-1:0] win_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
      end else begin
         s1_vld_ff <= acc;
         s2_vld_ff <= s1_vld_ff && s1_pos_ff.emit;
         s3_vld_ff <= s2_vld_ff;
         if (s1_vld_ff) begin
            win_ff[0] <= win_ff[1];
            win_ff[1] <= win_ff[2];
            win_ff[2] <= s1_up;
            win_ff[3] <= win_ff[4];
            win_ff[4] <= win_ff[5];
            win_ff[5] <= s1_mid;
            win_ff[6] <= win_ff[7];
            win_ff[7] <= win_ff[8];
            win_ff[8] <= s1_pix_ff;
         end
      end
      s1_pos_ff <= pos0;
      s1_col_ff <= rd_addr;
      s1_pix_ff <= pix0;
      s2_pos_ff <= s1_pos_ff;
      s3_pos_ff <= s2_pos_ff;
   end

   // taps outside the frame read as zero
   logic [2:0] row_ok, col_ok;
   logic       tap_use [9];

   always_comb begin
      row_ok = {!s2_pos_ff.bot, 1'b1, !s2_pos_ff.top};
      col_ok = {!s2_pos_ff.right, 1'b1, !s2_pos_ff.left};
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            tap_use[r*3 + c] = row_ok[r] && col_ok[c];
         end
      end
   end

   logic [cpif_pkg::SAMPLE_W-1:0] res [3];

   for (genvar ch = 0; ch < 3; ch++) begin : g_ch
      if (ch < CHANNELS) begin : g_on
         logic [7:0]  tap [9];
         logic [11:0] s_cor, s_edg, s_all;
         logic [13:0] v;
         logic [13:0] s3_val_ff;
         logic [28:0] prod;
         logic [11:0] q;
         logic        en;

         // kernel sums scaled down by the common factor of each kernel
         always_comb begin
            for (int k = 0; k < 9; k++) begin
               tap[k] = tap_use[k] ? win_ff[k][ch*8 +: 8] : 8'd0;
            end
            s_cor = 12'(tap[0]) + 12'(tap[2]) + 12'(tap[6]) + 12'(tap[8]);
            s_edg = 12'(tap[1]) + 12'(tap[3]) + 12'(tap[5]) + 12'(tap[7]);
            s_all = s_cor + s_edg + 12'(tap[4]);
            case (mode_ff)
               cpif_pkg::MODE_BLUR:
                  v = 14'(s_cor) + 14'({s_edg, 1'b0}) + 14'({tap[4], 2'b00});
               cpif_pkg::MODE_SHARPEN:
                  v = 14'(tap[4]) * 14'd11 - 14'({s_edg, 1'b0});
               cpif_pkg::MODE_MEAN:
                  v = 14'(tap[4]) * 14'd10 - 14'(s_all);
               cpif_pkg::MODE_EMBOSS:
                  v = 14'(tap[7]) - 14'(tap[1]);
               default:
                  v = 14'(s_all);
            endcase
         end

         always_ff @(posedge clock) begin
            s3_val_ff <= v;
         end

         // floor division, then clamp; non-positive sums give zero
         always_comb begin
            en   = (ch == 0) || color_ff;
            prod = '0;
            case (mode_ff)
               cpif_pkg::MODE_BLUR: begin
                  q = 12'(s3_val_ff[12:4]);
               end
               cpif_pkg::MODE_SHARPEN: begin
                  prod = 29'(s3_val_ff[12:0]) * 29'(cpif_pkg::RECIP_THREE);
                  q    = prod[cpif_pkg::RECIP_SHIFT +: 12];
               end
               cpif_pkg::MODE_MEAN, cpif_pkg::MODE_EMBOSS: begin
                  q = s3_val_ff[11:0];
               end
               default: begin
                  prod = 29'(s3_val_ff[12:0]) * 29'(cpif_pkg::RECIP_NINE);
                  q    = prod[cpif_pkg::RECIP_SHIFT +: 12];
               end
            endcase
            if (!en || s3_val_ff[13] || (s3_val_ff == '0)) begin
               res[ch] = '0;
            end else if (q > 12'(maxv_ff)) begin
               res[ch] = maxv_ff;
            end else begin
               res[ch] = q[7:0];
            end
         end
      end else begin : g_off
         assign res[ch] = '0;
      end
   end

   // ---------------------------------------------------------------- result queue
   cpif_pkg::rsp_type outq [cpif_pkg::OUTQ_DEPTH];
   cpif_pkg::rsp_type push_data;
   logic [QA-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic              pop;

   always_comb begin
      push_data.result_a   = res[0];
      push_data.result_b   = res[1];
      push_data.result_c   = res[2];
      push_data.frame_last = s3_pos_ff.last;
   end

   assign rsp_valid = (outq_cnt_ff != '0);
   assign rsp_data  = outq[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (s3_vld_ff) outq[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         outq_cnt_ff <= '0;
      end else begin
         if (s3_vld_ff) wr_ptr_ff <= wr_ptr_ff + QA'(1);
         if (pop) rd_ptr_ff <= rd_ptr_ff + QA'(1);
         outq_cnt_ff <= outq_cnt_ff + (QA+1)'(s3_vld_ff) - (QA+1)'(pop);
      end
   end

`ifndef SYNTH
   a_acc_in_run: assert property (@(posedge clock) disable iff (reset)
      acc |-> state_ff == cpif_pkg::ST_RUN)
      else $error("transfer taken outside run state");

   a_outq_bound: assert property (@(posedge clock) disable iff (reset)
      outq_cnt_ff <= (QA+1)'(cpif_pkg::OUTQ_DEPTH))
      else $error("result queue count out of range");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      s3_vld_ff |-> outq_cnt_ff < (QA+1)'(cpif_pkg::OUTQ_DEPTH))
      else $error("result pushed into full queue");

   a_fwd_live: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> s1_vld_ff)
      else $error("bypass without a transfer in stage one");

   a_csr_recompute: assert property (@(posedge clock) disable iff (reset)
      csr_fire |=> state_ff == cpif_pkg::ST_DIV)
      else $error("register write did not start recompute");
`endif

endmodule
